FILE: design/ebu_pkg.sv
package ebu_pkg;

    localparam int CHAR_W = 8;

    // Request codes carried on the input channel.
    typedef enum logic [3:0] {
        REQ_INSERT    = 4'd0,
        REQ_BACKSPACE = 4'd1,
        REQ_UNDO      = 4'd2,
        REQ_REDO      = 4'd3,
        REQ_NEXT      = 4'd4,
        REQ_PREV      = 4'd5,
        REQ_HOME      = 4'd6,
        REQ_END       = 4'd7,
        REQ_READ      = 4'd8
    } t_req;

    // Status bit of every result.
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    // Kind bit held in each journal entry.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // Shift command from the sequencer to the row of text cells.
    typedef struct packed {
        logic en;
        logic del;
    } t_shift_cmd;

    // Per-cell load selection, decoded by the row for each cell.
    typedef struct packed {
        logic take_new;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

endpackage

FILE: design/edit_buffer_with_undo_redo.sv
// Edit buffer with undo and redo journals.
// Requests enter on the input channel (i_in_valid / o_in_ready) as a request
// code, a character for inserts and an index for reads. Each transfer gives
// exactly one result on the output channel (o_out_valid / i_out_ready): a
// status bit, the cursor, the text length and, for a read, the character.
// The text sits in a row of character cells that shift left or right by one
// place; the two journals are RAMs with one write port and one read port.
// A request is taken in S_IDLE, when the journal top and the text character
// it needs are read, and is carried out in S_EXEC, which loads the result
// register once the output is free. A new request is not taken until the
// last one has been carried out.
// The next request is taken while a result still waits; if the receiver
// stalls, that request waits, with all state unchanged, until the held
// result has been transferred.
// Reset empties the text and both journals and homes the cursor; the
// contents of the cells and RAMs are not cleared and are never used before
// being written.
module edit_buffer_with_undo_redo #(
    parameter int BUFFER_CHARS  = 128,
    parameter int JOURNAL_DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [3:0]                            i_req_type,
    input  logic [ebu_pkg::CHAR_W-1:0]            i_char_in,
    input  logic [$clog2(BUFFER_CHARS)-1:0]       i_read_index,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_status,
    output logic [$clog2(BUFFER_CHARS+1)-1:0]     o_cursor_pos,
    output logic [$clog2(BUFFER_CHARS+1)-1:0]     o_text_length,
    output logic [ebu_pkg::CHAR_W-1:0]            o_read_char
);

    localparam int AW = $clog2(BUFFER_CHARS);
    localparam int CW = $clog2(BUFFER_CHARS + 1);
    localparam int JW = $clog2(JOURNAL_DEPTH);
    localparam int DW = $clog2(JOURNAL_DEPTH + 1);
    localparam int EW = 1 + ebu_pkg::CHAR_W + AW;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                     r_state;
    logic [3:0]                 r_req;
    logic [ebu_pkg::CHAR_W-1:0] r_ch;
    logic [AW-1:0]              r_idx;
    logic [CW-1:0]              r_cursor;
    logic [CW-1:0]              r_count;
    logic [DW-1:0]              r_undo_depth;
    logic [DW-1:0]              r_redo_depth;
    logic                       r_out_valid;
    logic                       r_res_status;
    logic [CW-1:0]              r_res_cursor;
    logic [CW-1:0]              r_res_length;
    logic [ebu_pkg::CHAR_W-1:0] r_res_char;

    logic                       in_xfer;
    logic                       exec_go;
    logic [AW-1:0]              sel_addr;
    logic [ebu_pkg::CHAR_W-1:0] sel_char;
    logic [EW-1:0]              undo_rdata;
    logic [EW-1:0]              redo_rdata;

    logic                       n_status;
    logic [CW-1:0]              n_cursor;
    logic [CW-1:0]              n_count;
    logic [DW-1:0]              n_undo_depth;
    logic [DW-1:0]              n_redo_depth;
    logic [ebu_pkg::CHAR_W-1:0] n_read_char;
    ebu_pkg::t_shift_cmd        shift_c;
    ebu_pkg::t_shift_cmd        shift_cmd;
    logic [AW-1:0]              shift_pos;
    logic [ebu_pkg::CHAR_W-1:0] shift_char;
    logic                       undo_we_c;
    logic                       redo_we_c;
    logic [EW-1:0]              undo_wdata;
    logic [EW-1:0]              redo_wdata;

    logic [EW-1:0]              pop_entry;
    logic                       e_kind;
    logic [ebu_pkg::CHAR_W-1:0] e_char;
    logic [AW-1:0]              e_pos;
    logic [CW-1:0]              e_pos_w;
    logic                       e_grow;
    logic                       e_fits;
    logic                       text_full;
    logic                       undo_room;
    logic                       redo_room;
    logic                       pop_empty;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // The only text character a request needs is the one before the cursor
    // for a backspace or the one at the index for a read.
    assign sel_addr = (i_req_type == ebu_pkg::REQ_BACKSPACE) ? AW'(r_cursor - CW'(1))
                                                             : i_read_index;

    ebu_text_row #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_text_row (
        .i_clk      (i_clk),
        .i_cmd      (shift_cmd),
        .i_pos      (shift_pos),
        .i_char     (shift_char),
        .i_sel_load (in_xfer),
        .i_sel_addr (sel_addr),
        .o_sel_char (sel_char)
    );

    ebu_ram #(
        .WIDTH (EW),
        .DEPTH (JOURNAL_DEPTH)
    ) u_undo_ram (
        .i_clk   (i_clk),
        .i_we    (exec_go && undo_we_c),
        .i_waddr (JW'(r_undo_depth)),
        .i_wdata (undo_wdata),
        .i_re    (in_xfer),
        .i_raddr (JW'(r_undo_depth - DW'(1))),
        .o_rdata (undo_rdata)
    );

    ebu_ram #(
        .WIDTH (EW),
        .DEPTH (JOURNAL_DEPTH)
    ) u_redo_ram (
        .i_clk   (i_clk),
        .i_we    (exec_go && redo_we_c),
        .i_waddr (JW'(r_redo_depth)),
        .i_wdata (redo_wdata),
        .i_re    (in_xfer),
        .i_raddr (JW'(r_redo_depth - DW'(1))),
        .o_rdata (redo_rdata)
    );

    assign pop_entry = (r_req == ebu_pkg::REQ_UNDO) ? undo_rdata : redo_rdata;
    assign e_kind    = pop_entry[EW-1];
    assign e_char    = pop_entry[EW-2 -: ebu_pkg::CHAR_W];
    assign e_pos     = pop_entry[AW-1:0];
    assign e_pos_w   = CW'(e_pos);

    assign text_full = (r_count >= CW'(BUFFER_CHARS));
    assign undo_room = (r_undo_depth < DW'(JOURNAL_DEPTH));
    assign redo_room = (r_redo_depth < DW'(JOURNAL_DEPTH));
    assign pop_empty = (r_req == ebu_pkg::REQ_UNDO) ? (r_undo_depth == '0)
                                                    : (r_redo_depth == '0);

    // Undoing a delete or redoing an insert grows the text.
    assign e_grow = (r_req == ebu_pkg::REQ_UNDO) ? (e_kind == ebu_pkg::KIND_DELETE)
                                                 : (e_kind == ebu_pkg::KIND_INSERT);
    assign e_fits = e_grow ? (!text_full && (e_pos_w <= r_count)) : (e_pos_w < r_count);

    always_comb begin
        n_status     = ebu_pkg::ST_DONE;
        n_cursor     = r_cursor;
        n_count      = r_count;
        n_undo_depth = r_undo_depth;
        n_redo_depth = r_redo_depth;
        n_read_char  = '0;
        shift_c      = '0;
        shift_pos    = '0;
        shift_char   = r_ch;
        undo_we_c    = 1'b0;
        redo_we_c    = 1'b0;
        undo_wdata   = '0;
        redo_wdata   = '0;

        unique case (r_req)
            ebu_pkg::REQ_INSERT: begin
                if (text_full) begin
                    n_status = ebu_pkg::ST_IGNORED;
                end else begin
                    shift_c.en   = 1'b1;
                    shift_pos    = AW'(r_cursor);
                    n_cursor     = r_cursor + CW'(1);
                    n_count      = r_count + CW'(1);
                    undo_we_c    = undo_room;
                    undo_wdata   = {ebu_pkg::KIND_INSERT, r_ch, AW'(r_cursor)};
                    n_undo_depth = undo_room ? r_undo_depth + DW'(1) : r_undo_depth;
                    n_redo_depth = '0;
                end
            end
            ebu_pkg::REQ_BACKSPACE: begin
                if (r_cursor == '0) begin
                    n_status = ebu_pkg::ST_IGNORED;
                end else begin
                    shift_c.en   = 1'b1;
                    shift_c.del  = 1'b1;
                    shift_pos    = AW'(r_cursor - CW'(1));
                    n_cursor     = r_cursor - CW'(1);
                    n_count      = r_count - CW'(1);
                    undo_we_c    = undo_room;
                    undo_wdata   = {ebu_pkg::KIND_DELETE, sel_char, AW'(r_cursor - CW'(1))};
                    n_undo_depth = undo_room ? r_undo_depth + DW'(1) : r_undo_depth;
                    n_redo_depth = '0;
                end
            end
            ebu_pkg::REQ_UNDO, ebu_pkg::REQ_REDO: begin
                if (pop_empty) begin
                    n_status = ebu_pkg::ST_IGNORED;
                end else begin
                    // The popped entry leaves its journal whether or not it fits.
                    if (r_req == ebu_pkg::REQ_UNDO) begin
                        n_undo_depth = r_undo_depth - DW'(1);
                    end else begin
                        n_redo_depth = r_redo_depth - DW'(1);
                    end
                    if (!e_fits) begin
                        n_status = ebu_pkg::ST_IGNORED;
                    end else begin
                        shift_c.en  = 1'b1;
                        shift_c.del = !e_grow;
                        shift_pos   = e_pos;
                        shift_char  = e_char;
                        if (e_grow) begin
                            n_cursor = e_pos_w + CW'(1);
                            n_count  = r_count + CW'(1);
                        end else begin
                            n_cursor = e_pos_w;
                            n_count  = r_count - CW'(1);
                        end
                        if (r_req == ebu_pkg::REQ_UNDO) begin
                            redo_we_c    = redo_room;
                            redo_wdata   = pop_entry;
                            n_redo_depth = redo_room ? r_redo_depth + DW'(1) : r_redo_depth;
                        end else begin
                            undo_we_c    = undo_room;
                            undo_wdata   = pop_entry;
                            n_undo_depth = undo_room ? r_undo_depth + DW'(1) : r_undo_depth;
                        end
                    end
                end
            end
            ebu_pkg::REQ_NEXT: begin
                if (r_cursor < r_count) begin
                    n_cursor = r_cursor + CW'(1);
                end else begin
                    n_status = ebu_pkg::ST_IGNORED;
                end
            end
            ebu_pkg::REQ_PREV: begin
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - CW'(1);
                end else begin
                    n_status = ebu_pkg::ST_IGNORED;
                end
            end
            ebu_pkg::REQ_HOME: begin
                n_cursor = '0;
            end
            ebu_pkg::REQ_END: begin
                n_cursor = r_count;
            end
            ebu_pkg::REQ_READ: begin
                if ((CW'(r_idx) < r_count) && (CW'(r_idx) < CW'(BUFFER_CHARS))) begin
                    n_read_char = sel_char;
                end else begin
                    n_status = ebu_pkg::ST_IGNORED;
                end
            end
            default: begin
                n_status = ebu_pkg::ST_IGNORED;
            end
        endcase
    end

    assign shift_cmd.en  = exec_go && shift_c.en;
    assign shift_cmd.del = shift_c.del;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cursor     <= '0;
            r_count      <= '0;
            r_undo_depth <= '0;
            r_redo_depth <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !exec_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_req_type;
                        r_ch    <= i_char_in;
                        r_idx   <= i_read_index;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_cursor     <= n_cursor;
                        r_count      <= n_count;
                        r_undo_depth <= n_undo_depth;
                        r_redo_depth <= n_redo_depth;
                        r_res_status <= n_status;
                        r_res_cursor <= n_cursor;
                        r_res_length <= n_count;
                        r_res_char   <= n_read_char;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res_status;
    assign o_cursor_pos  = r_res_cursor;
    assign o_text_length = r_res_length;
    assign o_read_char   = r_res_char;

endmodule

FILE: design/ebu_ram.sv
module ebu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ebu_cell.sv
module ebu_cell (
    input  logic                        i_clk,
    input  ebu_pkg::t_cell_ctl          i_ctl,
    input  logic [ebu_pkg::CHAR_W-1:0]  i_new,
    input  logic [ebu_pkg::CHAR_W-1:0]  i_left,
    input  logic [ebu_pkg::CHAR_W-1:0]  i_right,
    output logic [ebu_pkg::CHAR_W-1:0]  o_q
);

    logic [ebu_pkg::CHAR_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_new) begin
            r_q <= i_new;
        end else if (i_ctl.take_left) begin
            r_q <= i_left;
        end else if (i_ctl.take_right) begin
            r_q <= i_right;
        end
    end

    assign o_q = r_q;

endmodule

FILE: design/ebu_text_row.sv
module ebu_text_row #(
    parameter int BUFFER_CHARS = 128
) (
    input  logic                              i_clk,
    input  ebu_pkg::t_shift_cmd               i_cmd,
    input  logic [$clog2(BUFFER_CHARS)-1:0]   i_pos,
    input  logic [ebu_pkg::CHAR_W-1:0]        i_char,
    input  logic                              i_sel_load,
    input  logic [$clog2(BUFFER_CHARS)-1:0]   i_sel_addr,
    output logic [ebu_pkg::CHAR_W-1:0]        o_sel_char
);

    localparam int AW = $clog2(BUFFER_CHARS);

    logic [ebu_pkg::CHAR_W-1:0] cell_q [BUFFER_CHARS];
    logic [ebu_pkg::CHAR_W-1:0] r_sel_char;

    for (genvar i = 0; i < BUFFER_CHARS; i++) begin : g_cell
        localparam logic [AW-1:0] IDX = AW'(i);
        ebu_pkg::t_cell_ctl          ctl;
        logic [ebu_pkg::CHAR_W-1:0]  left_q;
        logic [ebu_pkg::CHAR_W-1:0]  right_q;

        // An insert moves every cell past the position one place right; a
        // delete moves the position and everything past it one place left.
        assign ctl.take_new   = i_cmd.en && !i_cmd.del && (IDX == i_pos);
        assign ctl.take_left  = i_cmd.en && !i_cmd.del && (IDX > i_pos);
        assign ctl.take_right = i_cmd.en && i_cmd.del && (IDX >= i_pos);

        if (i == 0) begin : g_first
            assign left_q = cell_q[i];
        end else begin : g_inner_l
            assign left_q = cell_q[i-1];
        end

        if (i == BUFFER_CHARS - 1) begin : g_last
            assign right_q = cell_q[i];
        end else begin : g_inner_r
            assign right_q = cell_q[i+1];
        end

        ebu_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_new   (i_char),
            .i_left  (left_q),
            .i_right (right_q),
            .o_q     (cell_q[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_sel_load) begin
            r_sel_char <= cell_q[i_sel_addr];
        end
    end

    assign o_sel_char = r_sel_char;

endmodule

FILE: bench/edit_buffer_with_undo_redo_tb.sv
`timescale 1ns / 100ps

module edit_buffer_with_undo_redo_tb;

    localparam int TEXT_CAP         = 128;
    localparam int JOURNAL_CAP      = 128;
    localparam int RANDOM_ITEMS     = 525;
    localparam int LONG_HOLD_AT     = 200;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 16;
    localparam int MAX_REPORTS      = 10;
    localparam int RUN_LIMIT_NS     = 400_000;

    localparam logic [3:0] REQ_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] REQ_UNUSED_LAST  = 4'd15;

    localparam int LOG_UNDO = 0;
    localparam int LOG_REDO = 1;

    typedef enum int {MIX_TYPING, MIX_ERASING, MIX_HISTORY, MIX_ANY} t_mix;

    typedef struct packed {
        logic       status;
        logic [7:0] cursor;
        logic [7:0] length;
        logic [7:0] rd;
    } t_result;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [7:0] pos;
    } t_edit_rec;

    typedef struct packed {
        logic [3:0] req;
        logic [7:0] ch;
        logic [6:0] idx;
        logic       typed;
        t_result    want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [3:0] i_req_type;
    logic [7:0] i_char_in;
    logic [6:0] i_read_index;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_status;
    logic [7:0] o_cursor_pos;
    logic [7:0] o_text_length;
    logic [7:0] o_read_char;

    edit_buffer_with_undo_redo #(
        .BUFFER_CHARS  (TEXT_CAP),
        .JOURNAL_DEPTH (JOURNAL_CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_char_in     (i_char_in),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_cursor_pos  (o_cursor_pos),
        .o_text_length (o_text_length),
        .o_read_char   (o_read_char)
    );

    // Shadow copy of the text, cursor and both journals.
    logic [7:0] model_text [TEXT_CAP];
    t_edit_rec  journal [2][JOURNAL_CAP];
    int         log_depth [2];
    int         model_len;
    int         model_cur;

    t_result    pending_results [$];
    t_stim_row  directed_rows [$];

    int  mismatches;
    int  results_checked;
    int  requests_sent;
    int  full_rejects;
    int  stale_discards;
    int  dropped_pushes;
    bit  feed_steady;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic void text_insert(int pos, logic [7:0] ch);
        int i;
        for (i = model_len; i > pos; i--) begin
            model_text[i] = model_text[i - 1];
        end
        model_text[pos] = ch;
        model_len++;
    endfunction

    function automatic void text_remove(int pos);
        int i;
        for (i = pos; i + 1 < model_len; i++) begin
            model_text[i] = model_text[i + 1];
        end
        model_len--;
    endfunction

    // A push onto a full journal is lost, but the request still counts as done.
    function automatic void log_push(int which, t_edit_rec rec);
        if (log_depth[which] < JOURNAL_CAP) begin
            journal[which][log_depth[which]] = rec;
            log_depth[which]++;
        end else begin
            dropped_pushes++;
        end
    endfunction

    // Replays one journal entry; false when it no longer fits the text.
    function automatic bit replay_entry(t_edit_rec rec, bit forward);
        bit grow;
        grow = ((rec.kind == ebu_pkg::KIND_INSERT) == forward);
        if (grow) begin
            if (model_len >= TEXT_CAP || rec.pos > model_len) return 1'b0;
            text_insert(rec.pos, rec.ch);
            model_cur = rec.pos + 1;
        end else begin
            if (rec.pos >= model_len) return 1'b0;
            text_remove(rec.pos);
            model_cur = rec.pos;
        end
        return 1'b1;
    endfunction

    function automatic t_result apply_request(logic [3:0] req, logic [7:0] ch,
                                              logic [6:0] idx);
        t_result    r;
        t_edit_rec  rec;
        logic [7:0] pos8;
        int         src;
        bit         forward;
        r.status = ebu_pkg::ST_DONE;
        r.rd     = 8'h00;
        case (req)
            ebu_pkg::REQ_INSERT: begin
                if (model_len >= TEXT_CAP) begin
                    r.status = ebu_pkg::ST_IGNORED;
                    full_rejects++;
                end else begin
                    pos8 = 8'(model_cur);
                    text_insert(model_cur, ch);
                    model_cur++;
                    log_push(LOG_UNDO, {ebu_pkg::KIND_INSERT, ch, pos8});
                    log_depth[LOG_REDO] = 0;
                end
            end
            ebu_pkg::REQ_BACKSPACE: begin
                if (model_cur == 0) begin
                    r.status = ebu_pkg::ST_IGNORED;
                end else begin
                    rec.ch = model_text[model_cur - 1];
                    text_remove(model_cur - 1);
                    model_cur--;
                    pos8 = 8'(model_cur);
                    log_push(LOG_UNDO, {ebu_pkg::KIND_DELETE, rec.ch, pos8});
                    log_depth[LOG_REDO] = 0;
                end
            end
            ebu_pkg::REQ_UNDO, ebu_pkg::REQ_REDO: begin
                forward = (req == ebu_pkg::REQ_REDO);
                src     = forward ? LOG_REDO : LOG_UNDO;
                if (log_depth[src] == 0) begin
                    r.status = ebu_pkg::ST_IGNORED;
                end else begin
                    log_depth[src]--;
                    rec = journal[src][log_depth[src]];
                    if (replay_entry(rec, forward)) begin
                        log_push(forward ? LOG_UNDO : LOG_REDO, rec);
                    end else begin
                        r.status = ebu_pkg::ST_IGNORED;
                        stale_discards++;
                    end
                end
            end
            ebu_pkg::REQ_NEXT: begin
                if (model_cur < model_len) model_cur++;
                else r.status = ebu_pkg::ST_IGNORED;
            end
            ebu_pkg::REQ_PREV: begin
                if (model_cur > 0) model_cur--;
                else r.status = ebu_pkg::ST_IGNORED;
            end
            ebu_pkg::REQ_HOME: model_cur = 0;
            ebu_pkg::REQ_END:  model_cur = model_len;
            ebu_pkg::REQ_READ: begin
                if (idx < model_len) r.rd = model_text[idx];
                else r.status = ebu_pkg::ST_IGNORED;
            end
            default: r.status = ebu_pkg::ST_IGNORED;
        endcase
        r.cursor = 8'(model_cur);
        r.length = 8'(model_len);
        return r;
    endfunction

    function automatic t_stim_row tab(logic [3:0] req, logic [7:0] ch, logic [6:0] idx,
                                      logic typed, logic st, logic [7:0] cur,
                                      logic [7:0] len, logic [7:0] rd);
        t_stim_row row;
        row.req         = req;
        row.ch          = ch;
        row.idx         = idx;
        row.typed       = typed;
        row.want.status = st;
        row.want.cursor = cur;
        row.want.length = len;
        row.want.rd     = rd;
        return row;
    endfunction

    function automatic logic [3:0] pick_request(t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_TYPING: begin
                if (roll < 80) return ebu_pkg::REQ_INSERT;
                if (roll < 85) return ebu_pkg::REQ_PREV;
                if (roll < 88) return ebu_pkg::REQ_HOME;
                if (roll < 90) return ebu_pkg::REQ_NEXT;
                if (roll < 93) return ebu_pkg::REQ_END;
                if (roll < 97) return ebu_pkg::REQ_READ;
                return ebu_pkg::REQ_BACKSPACE;
            end
            MIX_ERASING: begin
                if (roll < 65) return ebu_pkg::REQ_BACKSPACE;
                if (roll < 75) return ebu_pkg::REQ_NEXT;
                if (roll < 80) return ebu_pkg::REQ_END;
                if (roll < 90) return ebu_pkg::REQ_READ;
                if (roll < 95) return ebu_pkg::REQ_INSERT;
                return ebu_pkg::REQ_UNDO;
            end
            MIX_HISTORY: begin
                if (roll < 45) return ebu_pkg::REQ_UNDO;
                if (roll < 80) return ebu_pkg::REQ_REDO;
                if (roll < 88) return ebu_pkg::REQ_INSERT;
                if (roll < 93) return ebu_pkg::REQ_BACKSPACE;
                return ebu_pkg::REQ_READ;
            end
            default: begin
                if (roll < 25) return ebu_pkg::REQ_INSERT;
                if (roll < 40) return ebu_pkg::REQ_BACKSPACE;
                if (roll < 50) return ebu_pkg::REQ_UNDO;
                if (roll < 60) return ebu_pkg::REQ_REDO;
                if (roll < 66) return ebu_pkg::REQ_NEXT;
                if (roll < 72) return ebu_pkg::REQ_PREV;
                if (roll < 76) return ebu_pkg::REQ_HOME;
                if (roll < 80) return ebu_pkg::REQ_END;
                if (roll < 95) return ebu_pkg::REQ_READ;
                return 4'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
            end
        endcase
    endfunction

    // Offers one request, waits for its transfer and records what should come back.
    task automatic send_item(logic [3:0] req, logic [7:0] ch, logic [6:0] idx,
                             logic typed, t_result want);
        int      gap;
        t_result predicted;
        gap = feed_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_char_in    <= ch;
        i_read_index <= idx;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predicted = apply_request(req, ch, idx);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic note_mismatch(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: want st=%0d cur=%0d len=%0d rd=%02h,",
                     $realtime, what, want.status, want.cursor, want.length, want.rd);
            $display("    got st=%0d cur=%0d len=%0d rd=%02h",
                     got.status, got.cursor, got.length, got.rd);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status = o_status;
            got.cursor = o_cursor_pos;
            got.length = o_text_length;
            got.rd     = o_read_char;
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.status !== want.status || got.cursor !== want.cursor ||
                    got.length !== want.length || got.rd !== want.rd) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // The receiver stalls at random, and once for a long stretch so that the
    // held result blocks the next request and the input stops taking transfers.
    initial begin : result_sink
        int stall;
        int taken;
        bit sink_steady;
        i_out_ready = 1'b0;
        taken       = 0;
        sink_steady = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken % 25 == 0) sink_steady = ($urandom_range(0, 2) == 0);
            if (taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
            else if (sink_steady) stall = 0;
            else stall = $urandom_range(0, 12);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            taken++;
        end
    end

    initial begin : stimulus
        int         i;
        int         random_sent;
        int         seg_len;
        t_mix       mix;
        logic [3:0] req;
        logic [7:0] ch;
        logic [6:0] idx;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = ebu_pkg::REQ_HOME;
        i_char_in    = 8'h00;
        i_read_index = 7'd0;
        mismatches      = 0;
        results_checked = 0;
        requests_sent   = 0;
        full_rejects    = 0;
        stale_discards  = 0;
        dropped_pushes  = 0;
        feed_steady     = 1'b0;
        model_len       = 0;
        model_cur       = 0;
        log_depth[LOG_UNDO] = 0;
        log_depth[LOG_REDO] = 0;

        // Empty-buffer corners first, then a few edits whose effect is checked
        // against the table values or, where a row is not typed, by the shadow model.
        directed_rows.push_back(tab(ebu_pkg::REQ_BACKSPACE, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_UNDO, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_REDO, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_NEXT, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_PREV, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_HOME, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_DONE, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_END, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_DONE, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_READ, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_READ, 8'hFF, 7'd127, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(REQ_UNUSED_FIRST, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(REQ_UNUSED_LAST, 8'hFF, 7'd127, 1,
                                    ebu_pkg::ST_IGNORED, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_INSERT, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_DONE, 1, 1, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_INSERT, 8'hFF, 7'd0, 1,
                                    ebu_pkg::ST_DONE, 2, 2, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_READ, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_DONE, 2, 2, 8'h00));
        directed_rows.push_back(tab(ebu_pkg::REQ_READ, 8'h00, 7'd1, 1,
                                    ebu_pkg::ST_DONE, 2, 2, 8'hFF));
        directed_rows.push_back(tab(ebu_pkg::REQ_HOME, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_DONE, 0, 2, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_PREV, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 0, 2, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_INSERT, 8'h5A, 7'd0, 0, 0, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_END, 8'h00, 7'd0, 0, 0, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_NEXT, 8'h00, 7'd0, 1,
                                    ebu_pkg::ST_IGNORED, 3, 3, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_BACKSPACE, 8'h00, 7'd0, 0, 0, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_UNDO, 8'h00, 7'd0, 0, 0, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_UNDO, 8'h00, 7'd0, 0, 0, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_REDO, 8'h00, 7'd0, 0, 0, 0, 0, 0));
        directed_rows.push_back(tab(ebu_pkg::REQ_READ, 8'h00, 7'd2, 0, 0, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++) begin
            send_item(directed_rows[i].req, directed_rows[i].ch, directed_rows[i].idx,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // A long typing run fills the buffer and the undo journal, erasing then
        // leaves journal entries that point past the text, and an undo/redo run
        // tries to replay them. Mixed stretches of random length follow.
        random_sent = 0;
        i = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (i)
                0:       begin mix = MIX_TYPING;  seg_len = 150; end
                1:       begin mix = MIX_ERASING; seg_len = 60;  end
                2:       begin mix = MIX_HISTORY; seg_len = 70;  end
                default: begin
                    mix     = t_mix'($urandom_range(0, 3));
                    seg_len = $urandom_range(10, 40);
                end
            endcase
            feed_steady = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                req = pick_request(mix);
                ch  = 8'($urandom_range(0, 255));
                if (model_len > 0 && $urandom_range(0, 4) != 0) begin
                    idx = 7'($urandom_range(0, model_len - 1));
                end else begin
                    idx = 7'($urandom_range(0, 127));
                end
                send_item(req, ch, idx, 1'b0, '0);
                random_sent++;
            end
            i++;
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d requests (%0d directed), %0d results checked, %0d mismatches",
                 requests_sent, directed_rows.size(), results_checked, mismatches);
        $display("summary: %0d full-buffer inserts refused, %0d stale entries dropped,",
                 full_rejects, stale_discards);
        $display("summary: %0d journal pushes lost", dropped_pushes);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/ebu_pkg.sv
design/ebu_ram.sv
design/ebu_cell.sv
design/ebu_text_row.sv
design/edit_buffer_with_undo_redo.sv
bench/edit_buffer_with_undo_redo_tb.sv
